// ===== design/ctmf_pkg.sv =====
// shared constants, types and helpers of the corner temporal median filter
`default_nettype none
package ctmf_pkg;

  // window and slot geometry
  localparam int WINDOW  = 13;
  localparam int QUADS   = 2;
  localparam int CORNERS = 4;
  localparam int SLOTS   = QUADS * CORNERS;
  localparam int DEPTH   = SLOTS * WINDOW;

  // field widths
  localparam int QUAD_W   = 1;
  localparam int CORNER_W = 2;
  localparam int COORD_W  = 12;

  // derived widths
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int MED_IDX = WINDOW / 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam coord_t COORD_MAX = '1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;     // transaction accepted, latch item and clear sorters
    logic scan;      // one window step: read, write if due, advance counter
    logic load_out;  // move medians into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_last; // current step is the last window position
    logic out_free;  // output register can take a new result
  } status_t;

  // slot number of a corner, indexes reduced modulo the configured counts
  function automatic slot_t slot_of(input logic [QUAD_W-1:0] q,
                                    input logic [CORNER_W-1:0] c);
    logic [3:0] cm;
    logic [3:0] qm;
    logic [7:0] s;
    cm = {2'b00, c};
    for (int i = 0; i < 4; i++) begin
      if (cm >= 4'(CORNERS)) begin
        cm = cm - 4'(CORNERS);
      end
    end
    qm = (QUADS == 1) ? 4'd0 : {3'b000, q};
    s = 8'(qm * 4'(CORNERS)) + {4'b0000, cm};
    return s[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/ctmf_in_if.sv =====
// input channel: one measured corner per transaction
`default_nettype none
interface ctmf_in_if;
  logic                              valid;
  logic                              ready;
  logic [ctmf_pkg::QUAD_W-1:0]       quad_index;
  logic [ctmf_pkg::CORNER_W-1:0]     corner_index;
  ctmf_pkg::coord_t                  x_coord;
  ctmf_pkg::coord_t                  y_coord;

  modport source (output valid, quad_index, corner_index, x_coord, y_coord,
                  input ready);
  modport sink   (input valid, quad_index, corner_index, x_coord, y_coord,
                  output ready);
endinterface
`default_nettype wire

// ===== design/ctmf_out_if.sv =====
// output channel: one filtered corner per transaction
`default_nettype none
interface ctmf_out_if;
  logic                              valid;
  logic                              ready;
  logic [ctmf_pkg::QUAD_W-1:0]       out_quad;
  logic [ctmf_pkg::CORNER_W-1:0]     out_corner;
  ctmf_pkg::coord_t                  median_x;
  ctmf_pkg::coord_t                  median_y;

  modport source (output valid, out_quad, out_corner, median_x, median_y,
                  input ready);
  modport sink   (input valid, out_quad, out_corner, median_x, median_y,
                  output ready);
endinterface
`default_nettype wire

// ===== design/ctmf_sorter.sv =====
// insertion sorter row keeps a window sorted ascending, one sample per cycle while insert is high
`default_nettype none
module ctmf_sorter (
  input  wire logic             clk,
  input  wire logic             clear,
  input  wire logic             insert,
  input  wire ctmf_pkg::coord_t value,
  output ctmf_pkg::coord_t      median
);

  ctmf_pkg::coord_t cells      [ctmf_pkg::WINDOW];
  ctmf_pkg::coord_t cells_next [ctmf_pkg::WINDOW];

  // each cell keeps, takes the new value or takes its left neighbor
  always_comb begin
    cells_next[0] = (cells[0] <= value) ? cells[0] : value;
    for (int i = 1; i < ctmf_pkg::WINDOW; i++) begin
      if (cells[i] <= value) begin
        cells_next[i] = cells[i];
      end else if (cells[i-1] <= value) begin
        cells_next[i] = value;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  // empty cells hold the largest code so real samples push them out
  always_ff @(posedge clk) begin
    for (int i = 0; i < ctmf_pkg::WINDOW; i++) begin
      if (clear) begin
        cells[i] <= ctmf_pkg::COORD_MAX;
      end else if (insert) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  assign median = cells[ctmf_pkg::MED_IDX];

endmodule
`default_nettype wire

// ===== design/ctmf_datapath.sv =====
// datapath: history memories, slot bookkeeping, window scan and output register
`default_nettype none
module ctmf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ctmf_pkg::cmd_t                cmd,
  output ctmf_pkg::status_t                  status,
  input  wire logic [ctmf_pkg::QUAD_W-1:0]   quad_index,
  input  wire logic [ctmf_pkg::CORNER_W-1:0] corner_index,
  input  wire ctmf_pkg::coord_t              x_coord,
  input  wire ctmf_pkg::coord_t              y_coord,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [ctmf_pkg::QUAD_W-1:0]        out_quad,
  output logic [ctmf_pkg::CORNER_W-1:0]      out_corner,
  output ctmf_pkg::coord_t                   median_x,
  output ctmf_pkg::coord_t                   median_y
);

  // history memories, one window per slot
  ctmf_pkg::coord_t mem_x [ctmf_pkg::DEPTH];
  ctmf_pkg::coord_t mem_y [ctmf_pkg::DEPTH];
  ctmf_pkg::coord_t rd_x;
  ctmf_pkg::coord_t rd_y;

  // per-slot bookkeeping
  ctmf_pkg::pos_t   pos    [ctmf_pkg::SLOTS];
  logic             primed [ctmf_pkg::SLOTS];

  // latched item
  logic [ctmf_pkg::QUAD_W-1:0]   q_reg;
  logic [ctmf_pkg::CORNER_W-1:0] c_reg;
  ctmf_pkg::coord_t              x_reg;
  ctmf_pkg::coord_t              y_reg;
  ctmf_pkg::addr_t               base;
  ctmf_pkg::pos_t                p_reg;
  logic                          fill;

  // scan state
  ctmf_pkg::cnt_t   k;
  logic             ins_pending;
  logic             take_new;
  ctmf_pkg::addr_t  addr;
  logic             wr_en;
  logic             hit;

  // slot lookup for the incoming item
  ctmf_pkg::slot_t  slot_in;
  ctmf_pkg::pos_t   p_cur;
  ctmf_pkg::pos_t   p_safe;
  ctmf_pkg::pos_t   p_inc;

  ctmf_pkg::coord_t ins_x;
  ctmf_pkg::coord_t ins_y;
  ctmf_pkg::coord_t med_x;
  ctmf_pkg::coord_t med_y;

  always_comb begin
    slot_in = ctmf_pkg::slot_of(quad_index, corner_index);
    p_cur   = pos[slot_in];
    p_safe  = ({1'b0, p_cur} >= (ctmf_pkg::POS_W+1)'(ctmf_pkg::WINDOW)) ? '0 : p_cur;
    p_inc   = (p_safe == ctmf_pkg::POS_W'(ctmf_pkg::WINDOW - 1)) ? '0 : p_safe + 1'b1;
  end

  // latch the item and update slot bookkeeping on a transaction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_reg <= quad_index;
      c_reg <= corner_index;
      x_reg <= x_coord;
      y_reg <= y_coord;
      base  <= ctmf_pkg::ADDR_W'(32'(slot_in) * ctmf_pkg::WINDOW);
      p_reg <= p_safe;
      fill  <= !primed[slot_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ctmf_pkg::SLOTS; i++) begin
        pos[i]    <= '0;
        primed[i] <= 1'b0;
      end
    end else if (cmd.start) begin
      primed[slot_in] <= 1'b1;
      pos[slot_in]    <= primed[slot_in] ? p_inc : '0;
    end
  end

  // window step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.start) begin
      k <= '0;
    end else if (cmd.scan) begin
      k <= k + 1'b1;
    end
  end

  assign hit    = (k == ctmf_pkg::CNT_W'(p_reg));
  assign wr_en  = cmd.scan && (fill || hit);
  assign addr   = base + ctmf_pkg::ADDR_W'(k);
  assign status.scan_last = (k == ctmf_pkg::CNT_W'(ctmf_pkg::WINDOW - 1));
  assign status.out_free  = !out_valid || out_ready;

  // history memories: write the new sample where due, read every step
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[addr] <= x_reg;
      mem_y[addr] <= y_reg;
    end
    rd_x <= mem_x[addr];
    rd_y <= mem_y[addr];
  end

  // read data lands in the next cycle; the new sample bypasses the stale read
  always_ff @(posedge clk) begin
    if (rst) begin
      ins_pending <= 1'b0;
    end else begin
      ins_pending <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    take_new <= fill || hit;
  end

  assign ins_x = take_new ? x_reg : rd_x;
  assign ins_y = take_new ? y_reg : rd_y;

  ctmf_sorter u_sort_x (
    .clk    (clk),
    .clear  (cmd.start),
    .insert (ins_pending),
    .value  (ins_x),
    .median (med_x)
  );

  ctmf_sorter u_sort_y (
    .clk    (clk),
    .clear  (cmd.start),
    .insert (ins_pending),
    .value  (ins_y),
    .median (med_y)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_quad   <= q_reg;
      out_corner <= c_reg;
      median_x   <= med_x;
      median_y   <= med_y;
    end
  end

  // a result is only loaded when the previous one is gone
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a pending result");

  // the scan never runs past the window
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (k <= ctmf_pkg::CNT_W'(ctmf_pkg::WINDOW - 1)))
    else $error("window scan out of range");

  // the replaced position lies inside the window
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> ({1'b0, p_reg} < (ctmf_pkg::POS_W+1)'(ctmf_pkg::WINDOW)))
    else $error("oldest position outside window");

endmodule
`default_nettype wire

// ===== design/ctmf_ctrl.sv =====
// controller: sequences accept, window scan, final insert and result hand-off
`default_nettype none
module ctmf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ctmf_pkg::status_t   status,
  output ctmf_pkg::cmd_t           cmd
);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    SCAN = 4'b0010,
    LAST = 4'b0100,
    DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.scan     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = LAST;
        end
      end
      LAST: begin
        state_next = DONE;
      end
      DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/corner_temporal_median_filter.sv =====
// Temporal median filter for tracked quadrilateral corners. Each input
// transaction names a slot (quad, corner) and carries an x and y coordinate;
// one output transaction per input returns the slot's indexes and the median
// of its last WINDOW samples for x and for y. A slot's first sample after
// reset fills its whole window. Items are handled one at a time, from accept to
// the next accept: the accept, then a scan of each window position through the
// single read port of the history memory into an insertion sorter, a step for
// the last read to land, and the load of the output register once it is free.
// A finished result waits in the output register while the next item is
// accepted and scanned.
`default_nettype none
module corner_temporal_median_filter (
  input  wire logic  clk,
  input  wire logic  rst,
  ctmf_in_if.sink    in_ch,
  ctmf_out_if.source out_ch
);

  ctmf_pkg::cmd_t    cmd;
  ctmf_pkg::status_t status;

  ctmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ctmf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .quad_index   (in_ch.quad_index),
    .corner_index (in_ch.corner_index),
    .x_coord      (in_ch.x_coord),
    .y_coord      (in_ch.y_coord),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_quad     (out_ch.out_quad),
    .out_corner   (out_ch.out_corner),
    .median_x     (out_ch.median_x),
    .median_y     (out_ch.median_y)
  );

endmodule
`default_nettype wire

// ===== bench/tb_corner_temporal_median_filter.sv =====
// self-checking testbench of the corner temporal median filter
`timescale 1ns / 1ps
`default_nettype none
module tb_corner_temporal_median_filter;

  localparam int N_DIRECTED   = 19;
  localparam int N_RANDOM     = 1000;
  localparam int IDLE_PERCENT = 23;
  localparam int TAIL_CYCLES  = 4 * (ctmf_pkg::WINDOW + 3);
  localparam int HOLD_CYCLES  = 250;

  // one filtered corner as the block returns it
  typedef struct packed {
    logic [ctmf_pkg::QUAD_W-1:0]   quad;
    logic [ctmf_pkg::CORNER_W-1:0] corner;
    ctmf_pkg::coord_t              mx;
    ctmf_pkg::coord_t              my;
  } corner_result_t;

  // one directed row; the median is typed in only where it is obvious
  typedef struct packed {
    logic [ctmf_pkg::QUAD_W-1:0]   quad;
    logic [ctmf_pkg::CORNER_W-1:0] corner;
    ctmf_pkg::coord_t              x;
    ctmf_pkg::coord_t              y;
    logic                          typed;
    ctmf_pkg::coord_t              ex;
    ctmf_pkg::coord_t              ey;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ctmf_in_if  in_ch ();
  ctmf_out_if out_ch ();

  corner_temporal_median_filter DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter state kept by the bench
  ctmf_pkg::coord_t win_x [ctmf_pkg::SLOTS][ctmf_pkg::WINDOW];
  ctmf_pkg::coord_t win_y [ctmf_pkg::SLOTS][ctmf_pkg::WINDOW];
  int               next_pos [ctmf_pkg::SLOTS];
  bit               seen_slot [ctmf_pkg::SLOTS];

  corner_result_t pending_medians [$];
  stim_row_t      directed_rows [N_DIRECTED];
  int             track_x [ctmf_pkg::SLOTS];
  int             track_y [ctmf_pkg::SLOTS];
  int             mismatch_count = 0;
  int             results_seen = 0;
  int             corners_sent = 0;

  // median of one slot window, middle element after an ascending sort
  function automatic ctmf_pkg::coord_t window_median(input int slot, input bit use_y);
    ctmf_pkg::coord_t tmp [ctmf_pkg::WINDOW];
    ctmf_pkg::coord_t v;
    int               j;
    for (int i = 0; i < ctmf_pkg::WINDOW; i++) begin
      tmp[i] = use_y ? win_y[slot][i] : win_x[slot][i];
    end
    for (int i = 1; i < ctmf_pkg::WINDOW; i++) begin
      v = tmp[i];
      j = i;
      while (j > 0 && tmp[j-1] > v) begin
        tmp[j] = tmp[j-1];
        j--;
      end
      tmp[j] = v;
    end
    return tmp[ctmf_pkg::WINDOW/2];
  endfunction

  // update the slot window with one sample and return the filtered corner
  function automatic corner_result_t filter_corner(
      input logic [ctmf_pkg::QUAD_W-1:0] q,
      input logic [ctmf_pkg::CORNER_W-1:0] c,
      input ctmf_pkg::coord_t x, input ctmf_pkg::coord_t y);
    corner_result_t r;
    int             slot;
    slot = (int'(q) % ctmf_pkg::QUADS) * ctmf_pkg::CORNERS + (int'(c) % ctmf_pkg::CORNERS);
    if (!seen_slot[slot]) begin
      // first sample of a slot fills its whole window
      for (int k = 0; k < ctmf_pkg::WINDOW; k++) begin
        win_x[slot][k] = x;
        win_y[slot][k] = y;
      end
      next_pos[slot] = 0;
      seen_slot[slot] = 1'b1;
    end else begin
      win_x[slot][next_pos[slot]] = x;
      win_y[slot][next_pos[slot]] = y;
      next_pos[slot] = (next_pos[slot] + 1 >= ctmf_pkg::WINDOW) ? 0 : next_pos[slot] + 1;
    end
    r.quad   = q;
    r.corner = c;
    r.mx     = window_median(slot, 1'b0);
    r.my     = window_median(slot, 1'b1);
    return r;
  endfunction

  function automatic ctmf_pkg::coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > int'(ctmf_pkg::COORD_MAX)) return ctmf_pkg::COORD_MAX;
    return ctmf_pkg::coord_t'(v);
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // offer one corner until accepted, then queue its expected median
  task automatic offer_corner(input logic [ctmf_pkg::QUAD_W-1:0] q,
                              input logic [ctmf_pkg::CORNER_W-1:0] c,
                              input ctmf_pkg::coord_t x, input ctmf_pkg::coord_t y,
                              input logic typed, input ctmf_pkg::coord_t ex,
                              input ctmf_pkg::coord_t ey);
    corner_result_t r;
    in_ch.valid        <= 1'b1;
    in_ch.quad_index   <= q;
    in_ch.corner_index <= c;
    in_ch.x_coord      <= x;
    in_ch.y_coord      <= y;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = filter_corner(q, c, x, y);
    if (typed) begin
      r.mx = ex;
      r.my = ey;
    end
    pending_medians = {pending_medians, r};
    corners_sent++;
  endtask

  // random idle cycles on the input side
  task automatic sender_gap(input bit allow);
    if (allow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PERCENT) @(posedge clk);
    end
  endtask

  // output side: check each transaction, stall at random, one long hold-off, one stall-free run
  initial begin
    corner_result_t exp_r;
    int             hold_left;
    bit             held;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_medians.size() == 0) begin
          $error("unexpected result quad %0d corner %0d",
                 out_ch.out_quad, out_ch.out_corner);
          mismatch_count++;
        end else begin
          exp_r = pending_medians.pop_front();
          check_field("out_quad", int'(exp_r.quad), int'(out_ch.out_quad));
          check_field("out_corner", int'(exp_r.corner), int'(out_ch.out_corner));
          check_field("median_x", int'(exp_r.mx), int'(out_ch.median_x));
          check_field("median_y", int'(exp_r.my), int'(out_ch.median_y));
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (results_seen == 300 && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= 600 && results_seen < 800) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // input side: directed rows, then tracked corners with noise
  initial begin
    logic [ctmf_pkg::QUAD_W-1:0]   q;
    logic [ctmf_pkg::CORNER_W-1:0] c;
    ctmf_pkg::coord_t              x;
    ctmf_pkg::coord_t              y;
    int                            s;
    int                            mode;

    in_ch.valid        <= 1'b0;
    in_ch.quad_index   <= '0;
    in_ch.corner_index <= '0;
    in_ch.x_coord      <= '0;
    in_ch.y_coord      <= '0;
    rst <= 1'b1;

    directed_rows = '{
      // first sample of each slot fills the window, median equals the sample
      '{1'b0, 2'd0, 12'd0,    12'd4095, 1'b1, 12'd0,    12'd4095},
      // one opposite sample cannot move a full window
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b1, 12'd0,    12'd4095},
      '{1'b0, 2'd1, 12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095},
      '{1'b0, 2'd2, 12'd0,    12'd0,    1'b1, 12'd0,    12'd0},
      '{1'b0, 2'd3, 12'd2048, 12'd1024, 1'b1, 12'd2048, 12'd1024},
      '{1'b1, 2'd0, 12'd1,    12'd4094, 1'b1, 12'd1,    12'd4094},
      '{1'b1, 2'd1, 12'd4094, 12'd1,    1'b1, 12'd4094, 12'd1},
      '{1'b1, 2'd2, 12'hAAA,  12'h555,  1'b1, 12'hAAA,  12'h555},
      '{1'b1, 2'd3, 12'h555,  12'hAAA,  1'b1, 12'h555,  12'hAAA},
      // majority flip on slot 0 once seven of thirteen samples are high
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
      '{1'b0, 2'd0, 12'd4095, 12'd0,    1'b0, 12'd0,    12'd0},
      // mixed values on the last slot
      '{1'b1, 2'd3, 12'd100,  12'd3000, 1'b0, 12'd0,    12'd0},
      '{1'b1, 2'd3, 12'd4000, 12'd7,    1'b0, 12'd0,    12'd0},
      '{1'b1, 2'd3, 12'd1365, 12'd2730, 1'b0, 12'd0,    12'd0},
      '{1'b1, 2'd3, 12'd1365, 12'd2730, 1'b0, 12'd0,    12'd0}
    };

    for (int i = 0; i < ctmf_pkg::SLOTS; i++) begin
      track_x[i] = int'($urandom_range(0, 4095));
      track_y[i] = int'($urandom_range(0, 4095));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < N_DIRECTED; n++) begin
      sender_gap(1'b1);
      offer_corner(directed_rows[n].quad, directed_rows[n].corner, directed_rows[n].x,
                   directed_rows[n].y, directed_rows[n].typed, directed_rows[n].ex,
                   directed_rows[n].ey);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 800) begin
        // drain the block completely before going on
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_medians.size() != 0) @(posedge clk);
      end else begin
        sender_gap(!(n >= 400 && n < 600));
      end
      q = ctmf_pkg::QUAD_W'($urandom_range(0, 1));
      c = ctmf_pkg::CORNER_W'($urandom_range(0, 3));
      s = int'(q) * ctmf_pkg::CORNERS + int'(c);
      mode = int'($urandom_range(0, 99));
      // slow drift of the tracked corner
      track_x[s] = int'(clamp_coord(track_x[s] + int'($urandom_range(0, 6)) - 3));
      track_y[s] = int'(clamp_coord(track_y[s] + int'($urandom_range(0, 6)) - 3));
      if (mode < 60) begin
        x = clamp_coord(track_x[s] + int'($urandom_range(0, 16)) - 8);
        y = clamp_coord(track_y[s] + int'($urandom_range(0, 16)) - 8);
      end else if (mode < 75) begin
        x = ctmf_pkg::coord_t'($urandom_range(0, 4095));
        y = ctmf_pkg::coord_t'($urandom_range(0, 4095));
      end else if (mode < 85) begin
        x = $urandom_range(0, 1) ? ctmf_pkg::COORD_MAX : '0;
        y = $urandom_range(0, 1) ? ctmf_pkg::COORD_MAX : '0;
      end else begin
        // outlier on one coordinate only
        x = ctmf_pkg::coord_t'($urandom_range(0, 4095));
        y = clamp_coord(track_y[s] + int'($urandom_range(0, 4)) - 2);
      end
      offer_corner(q, c, x, y, 1'b0, '0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d corner transactions over all %0d slots, %0d filtered results checked",
             corners_sent, ctmf_pkg::SLOTS, results_seen);
    $display("included window fill, majority flips, extremes, long output stall and drain");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/ctmf_pkg.sv
design/ctmf_in_if.sv
design/ctmf_out_if.sv
design/ctmf_sorter.sv
design/ctmf_datapath.sv
design/ctmf_ctrl.sv
design/corner_temporal_median_filter.sv
bench/tb_corner_temporal_median_filter.sv
